// ----- rtl/lrf_pkg.sv -----
package lrf_pkg;

  localparam int WIDTH_DEF  = 128;
  localparam int HEIGHT_DEF = 64;

  localparam int COORD_W = 8;
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 8;
  localparam int ERR_W   = 12;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_LINE  = 2'd2,
    REQ_READ  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_FETCH,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic wipe;
    logic rd_pix;
    logic wr_pix;
    logic rd_idx;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      pt_ok;
    logic      line_ok;
    logic      wipe_last;
    logic      at_end;
    logic      out_free;
  } dp_sts_t;

endpackage

// ----- rtl/lrf_if.sv -----
interface lrf_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [lrf_pkg::COORD_W-1:0]   start_x;
  logic [lrf_pkg::COORD_W-1:0]   start_y;
  logic [lrf_pkg::COORD_W-1:0]   end_x;
  logic [lrf_pkg::COORD_W-1:0]   end_y;
  logic [lrf_pkg::INDEX_W-1:0]   read_index;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y, read_index,
    output ready
  );
endinterface

interface lrf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lrf_pkg::DATA_W-1:0]   read_data;
  logic                         ignored;

  modport source (
    output valid, read_data, ignored,
    input  ready
  );
  modport sink (
    input  valid, read_data, ignored,
    output ready
  );
endinterface

// ----- rtl/lrf_ctrl.sv -----
module lrf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrf_pkg::dp_sts_t sts,
  output lrf_pkg::dp_cmd_t cmd
);

  lrf_pkg::ctrl_state_t state;
  lrf_pkg::ctrl_state_t state_next;
  logic                 boot;
  logic                 boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrf_pkg::ST_WIPE;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      boot  <= boot_next;
    end
  end

  always_comb begin
    state_next = state;
    boot_next  = boot;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      lrf_pkg::ST_WIPE: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_last) begin
          boot_next  = 1'b0;
          state_next = boot ? lrf_pkg::ST_IDLE : lrf_pkg::ST_DONE;
        end
      end
      lrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.kind)
            lrf_pkg::REQ_CLEAR: state_next = lrf_pkg::ST_WIPE;
            lrf_pkg::REQ_PIXEL: state_next = sts.pt_ok ? lrf_pkg::ST_PLOT_RD : lrf_pkg::ST_DONE;
            lrf_pkg::REQ_LINE:  state_next = sts.line_ok ? lrf_pkg::ST_PLOT_RD : lrf_pkg::ST_DONE;
            lrf_pkg::REQ_READ:  state_next = lrf_pkg::ST_FETCH;
            default:            state_next = lrf_pkg::ST_DONE;
          endcase
        end
      end
      lrf_pkg::ST_PLOT_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = lrf_pkg::ST_PLOT_WR;
      end
      lrf_pkg::ST_PLOT_WR: begin
        cmd.wr_pix = 1'b1;
        state_next = sts.at_end ? lrf_pkg::ST_DONE : lrf_pkg::ST_PLOT_RD;
      end
      lrf_pkg::ST_FETCH: begin
        cmd.rd_idx = 1'b1;
        state_next = lrf_pkg::ST_DONE;
      end
      lrf_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lrf_dp.sv -----
module lrf_dp #(
  parameter int WIDTH  = lrf_pkg::WIDTH_DEF,
  parameter int HEIGHT = lrf_pkg::HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lrf_pkg::dp_cmd_t            cmd,
  output lrf_pkg::dp_sts_t            sts,
  input  logic [1:0]                  req_type,
  input  logic [lrf_pkg::COORD_W-1:0] start_x,
  input  logic [lrf_pkg::COORD_W-1:0] start_y,
  input  logic [lrf_pkg::COORD_W-1:0] end_x,
  input  logic [lrf_pkg::COORD_W-1:0] end_y,
  input  logic [lrf_pkg::INDEX_W-1:0] read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrf_pkg::DATA_W-1:0]  read_data,
  output logic                        ignored
);

  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int STORE_BYTES = WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CW          = lrf_pkg::COORD_W;
  localparam int EW          = lrf_pkg::ERR_W;

  lrf_pkg::req_kind_t kind;
  logic               pt_ok;
  logic               end_ok;
  logic               idx_ok;
  logic [CW-1:0]      tx;
  logic [CW-1:0]      ty;
  logic [CW-1:0]      adx;
  logic [CW-1:0]      ady;

  logic [CW-1:0]          xa;
  logic [CW-1:0]          ya;
  logic [CW-1:0]          xb;
  logic [CW-1:0]          yb;
  logic                   x_dec;
  logic                   y_dec;
  logic signed [EW-1:0]   dx;
  logic signed [EW-1:0]   dy;
  logic signed [EW-1:0]   err;
  logic signed [EW-1:0]   err_next;
  logic signed [EW-1:0]   e2;
  logic                   step_x;
  logic                   step_y;
  logic [ADDR_W-1:0]      idx;
  logic [ADDR_W-1:0]      cnt;
  logic                   res_read;
  logic                   res_ign;

  logic [ADDR_W-1:0]             pix_addr;
  logic [lrf_pkg::DATA_W-1:0]    pix_mask;
  logic [lrf_pkg::DATA_W-1:0]    mem [STORE_BYTES];
  logic [lrf_pkg::DATA_W-1:0]    mem_q;
  logic                          mem_we;
  logic                          mem_re;
  logic [ADDR_W-1:0]             waddr;
  logic [ADDR_W-1:0]             raddr;
  logic [lrf_pkg::DATA_W-1:0]    wdata;

  assign kind   = lrf_pkg::req_kind_t'(req_type);
  assign pt_ok  = (32'(start_x) < WIDTH) && (32'(start_y) < HEIGHT);
  assign end_ok = (32'(end_x) < WIDTH) && (32'(end_y) < HEIGHT);
  assign idx_ok = 32'(read_index) < STORE_BYTES;

  assign tx  = (kind == lrf_pkg::REQ_LINE) ? end_x : start_x;
  assign ty  = (kind == lrf_pkg::REQ_LINE) ? end_y : start_y;
  assign adx = (tx >= start_x) ? tx - start_x : start_x - tx;
  assign ady = (ty >= start_y) ? ty - start_y : start_y - ty;

  assign e2       = err <<< 1;
  assign step_x   = e2 >= dy;
  assign step_y   = e2 <= dx;
  assign err_next = err + (step_x ? dy : '0) + (step_y ? dx : '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xa       <= start_x;
      ya       <= start_y;
      xb       <= tx;
      yb       <= ty;
      x_dec    <= tx < start_x;
      y_dec    <= ty < start_y;
      dx       <= $signed({{(EW - CW){1'b0}}, adx});
      dy       <= -$signed({{(EW - CW){1'b0}}, ady});
      err      <= $signed({{(EW - CW){1'b0}}, adx}) - $signed({{(EW - CW){1'b0}}, ady});
      idx      <= ADDR_W'(read_index);
      res_read <= (kind == lrf_pkg::REQ_READ) && idx_ok;
      res_ign  <= ((kind == lrf_pkg::REQ_PIXEL) && !pt_ok) ||
                  ((kind == lrf_pkg::REQ_LINE) && !(pt_ok && end_ok));
    end else if (cmd.wr_pix) begin
      err <= err_next;
      if (step_x) begin
        xa <= x_dec ? xa - 1'b1 : xa + 1'b1;
      end
      if (step_y) begin
        ya <= y_dec ? ya - 1'b1 : ya + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      cnt <= '0;
    end else if (cmd.wipe) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign pix_addr = ADDR_W'(32'(xa) + 32'(ya[CW-1:3]) * WIDTH);
  assign pix_mask = lrf_pkg::DATA_W'(1) << ya[2:0];

  assign mem_we = cmd.wipe | cmd.wr_pix;
  assign mem_re = cmd.rd_pix | cmd.rd_idx;
  assign waddr  = cmd.wipe ? cnt : pix_addr;
  assign wdata  = cmd.wipe ? '0 : (mem_q | pix_mask);
  assign raddr  = cmd.rd_idx ? idx : pix_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= res_read ? mem_q : '0;
      ignored   <= res_ign;
    end
  end

  assign sts.kind      = kind;
  assign sts.pt_ok     = pt_ok;
  assign sts.line_ok   = pt_ok && end_ok;
  assign sts.wipe_last = cnt == ADDR_W'(STORE_BYTES - 1);
  assign sts.at_end    = (xa == xb) && (ya == yb);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/line_raster_framebuffer.sv -----
// Channel  Role    Beat payload
// req      sink    req_type, start_x, start_y, end_x, end_y, read_index
// rsp      source  read_data, ignored
//
// Each request is handled alone, and every pixel is a read-modify-write of
// the frame store (one read port, one write port): ST_PLOT_RD reads the byte,
// then ST_PLOT_WR writes it back with the pixel bit set.
// After reset the store is zeroed with req not ready. A finished beat
// waits in the output register while the next request is accepted; a
// stalled rsp holds the block only when it finishes.
module line_raster_framebuffer #(
  parameter int WIDTH  = lrf_pkg::WIDTH_DEF,
  parameter int HEIGHT = lrf_pkg::HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst,
  lrf_req_if.sink    req,
  lrf_rsp_if.source  rsp
);

  lrf_pkg::dp_cmd_t cmd;
  lrf_pkg::dp_sts_t sts;

  lrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrf_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .start_x    (req.start_x),
    .start_y    (req.start_y),
    .end_x      (req.end_x),
    .end_y      (req.end_y),
    .read_index (req.read_index),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .read_data  (rsp.read_data),
    .ignored    (rsp.ignored)
  );

endmodule

// ----- rtl/lrf_checker.sv -----
module lrf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [lrf_pkg::DATA_W-1:0] rsp_read_data,
  input logic                       rsp_ignored
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_ignored))
    else $error("rsp beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready right after an accepted beat");

  a_ignored_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ignored |-> rsp_read_data == '0)
    else $error("dropped request returned store data");

  a_reset_wipe: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block ready or responding right after reset");

endmodule

bind line_raster_framebuffer lrf_checker u_lrf_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_ignored   (rsp.ignored)
);
